// ===== rtl/kvt_pkg.sv =====
// ----------------------------------------------------------------------------
// kvt_pkg: shared types for the keyed value table
// Request and result codes, controller states, and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CHANGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        RES_OK        = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, restart scan
        logic advance;   // step slot index
        logic compare;   // scan compare cycle
        logic clear_wr;  // clearing pass write
        logic commit;    // apply request, load result register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic addr_last;  // slot index at last slot
        logic scan_done;  // key matched or last slot compared
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/kvt_datapath.sv =====
// ----------------------------------------------------------------------------
// kvt_datapath: slot memory, scan compare and result register
// Holds valid/key/value per slot in one memory, scans it one slot per cycle
// and commits the write-back and result for the current item.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_datapath #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kvt_pkg::cmd_t         cmd_i,
    output kvt_pkg::stat_t             stat_o,
    input  wire logic [1:0]            action,
    input  wire logic [KEY_BITS-1:0]   key,
    input  wire logic [VALUE_BITS-1:0] value_in,
    output logic [1:0]                 status,
    output logic [VALUE_BITS-1:0]      value_out
);

    localparam int IW = $clog2(ENTRIES);
    localparam int EW = 1 + KEY_BITS + VALUE_BITS;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic [EW-1:0] mem [ENTRIES];

    kvt_pkg::action_t        act_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   val_reg;

    logic [IW-1:0]  addr_reg, addr_next;
    logic [EW-1:0]  rd_data_reg;
    logic [IW-1:0]  rd_idx_reg;
    logic           data_vld_reg;

    logic                  hit_reg, free_reg;
    logic [IW-1:0]         hit_idx_reg, free_idx_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;

    logic [1:0]            out_status_reg;
    logic [VALUE_BITS-1:0] out_value_reg;

    logic                  rd_valid;
    logic [KEY_BITS-1:0]   rd_key;
    logic                  match;

    logic                  c_wr;
    logic [IW-1:0]         c_addr;
    logic                  c_vbit;
    logic [1:0]            c_status;
    logic [VALUE_BITS-1:0] c_value;

    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [EW-1:0]         wr_data;

    assign rd_valid = rd_data_reg[EW-1];
    assign rd_key   = rd_data_reg[EW-2 -: KEY_BITS];
    assign match    = data_vld_reg && rd_valid && (rd_key == key_reg);

    assign stat_o.addr_last = (addr_reg == LAST);
    assign stat_o.scan_done = data_vld_reg && (match || rd_idx_reg == LAST);

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd_i.load)
        begin
            addr_next = '0;
        end
        else if (cmd_i.advance && addr_reg != LAST)
        begin
            addr_next = addr_reg + 1'b1;
        end
    end

    // commit decision from the scan flags
    always_comb
    begin
        c_wr     = 1'b0;
        c_addr   = hit_idx_reg;
        c_vbit   = 1'b1;
        c_status = kvt_pkg::RES_OK;
        c_value  = '0;
        unique case (act_reg)
            kvt_pkg::ACT_INSERT:
            begin
                if (hit_reg)
                begin
                    c_wr = 1'b1;
                end
                else if (free_reg)
                begin
                    c_wr   = 1'b1;
                    c_addr = free_idx_reg;
                end
                else
                begin
                    c_status = kvt_pkg::RES_FULL;
                end
            end
            kvt_pkg::ACT_REMOVE:
            begin
                if (hit_reg)
                begin
                    c_wr    = 1'b1;
                    c_vbit  = 1'b0;
                    c_value = hit_val_reg;
                end
                else
                begin
                    c_status = kvt_pkg::RES_NOT_FOUND;
                end
            end
            kvt_pkg::ACT_FIND:
            begin
                if (hit_reg)
                begin
                    c_value = hit_val_reg;
                end
                else
                begin
                    c_status = kvt_pkg::RES_NOT_FOUND;
                end
            end
            kvt_pkg::ACT_CHANGE:
            begin
                if (hit_reg)
                begin
                    c_wr = 1'b1;
                end
                else
                begin
                    c_status = kvt_pkg::RES_NOT_FOUND;
                end
            end
            default:
            begin
                c_status = kvt_pkg::RES_NOT_FOUND;
            end
        endcase
    end

    assign wr_en   = cmd_i.clear_wr || (cmd_i.commit && c_wr);
    assign wr_addr = cmd_i.clear_wr ? addr_reg : c_addr;
    assign wr_data = cmd_i.clear_wr ? {1'b0, key_reg, val_reg}
                                    : {c_vbit, key_reg, val_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[addr_reg];
        rd_idx_reg  <= addr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_i.load)
        begin
            act_reg <= kvt_pkg::action_t'(action);
            key_reg <= key;
            val_reg <= value_in;
        end
        if (cmd_i.compare && match)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_val_reg <= rd_data_reg[VALUE_BITS-1:0];
        end
        if (cmd_i.compare && data_vld_reg && !rd_valid && !free_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd_i.commit)
        begin
            out_status_reg <= c_status;
            out_value_reg  <= c_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            data_vld_reg <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            addr_reg     <= addr_next;
            data_vld_reg <= cmd_i.compare && !cmd_i.load;
            if (cmd_i.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else if (cmd_i.compare)
            begin
                if (match)
                begin
                    hit_reg <= 1'b1;
                end
                if (data_vld_reg && !rd_valid)
                begin
                    free_reg <= 1'b1;
                end
            end
        end
    end

    assign status    = out_status_reg;
    assign value_out = out_value_reg;

`ifndef SYNTHESIS
    // first scan cycle after a load never carries compare data
    a_load_clears_data: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.load |=> !data_vld_reg)
        else $error("stale read data after load");

    // a matching compare ends the scan
    a_hit_stops_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.compare && match |-> stat_o.scan_done)
        else $error("match did not end scan");

    // a matching compare is recorded for the commit
    a_match_sets_hit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_i.compare && match |=> hit_reg)
        else $error("hit not recorded");
`endif

endmodule

`default_nettype wire

// ===== rtl/kvt_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvt_ctrl: request sequencer
// Runs the clearing pass after reset, then per item: accept, scan, commit.
// Owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output kvt_pkg::cmd_t       cmd_o,
    input  wire kvt_pkg::stat_t stat_i
);

    kvt_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kvt_pkg::ST_CLEAR:
            begin
                if (stat_i.addr_last)
                begin
                    state_next = kvt_pkg::ST_IDLE;
                end
            end
            kvt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = kvt_pkg::ST_SCAN;
                end
            end
            kvt_pkg::ST_SCAN:
            begin
                if (stat_i.scan_done)
                begin
                    state_next = kvt_pkg::ST_FINISH;
                end
            end
            kvt_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = kvt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kvt_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd_o    = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            kvt_pkg::ST_CLEAR:
            begin
                cmd_o.clear_wr = 1'b1;
                cmd_o.advance  = 1'b1;
            end
            kvt_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd_o.load = in_valid;
            end
            kvt_pkg::ST_SCAN:
            begin
                cmd_o.advance = 1'b1;
                cmd_o.compare = 1'b1;
            end
            kvt_pkg::ST_FINISH:
            begin
                cmd_o.commit = out_free;
            end
            default:
            begin
                cmd_o = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd_o.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kvt_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == kvt_pkg::ST_SCAN)
        else $error("accepted item did not start a scan");

    a_scan_to_finish: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kvt_pkg::ST_SCAN && stat_i.scan_done
        |=> state_reg == kvt_pkg::ST_FINISH)
        else $error("scan end missed");

    a_finish_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kvt_pkg::ST_FINISH && !out_valid_reg |=> out_valid_reg)
        else $error("result not presented");
`endif

endmodule

`default_nettype wire

// ===== rtl/keyed_value_table.sv =====
// ----------------------------------------------------------------------------
// keyed_value_table: bounded key/value map with insert, remove, find, change
// Items are handled one at a time; the next is accepted once the last commits.
// Reset: a clearing pass over every slot empties the table; in_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

// Structure
//   kvt_ctrl     : sequencer (clear pass, accept, scan, commit) and out_valid.
//   kvt_datapath : one memory word per slot holding {valid, key, value},
//                  read one slot per cycle with a registered read port.
// Per item:
//   accept  - request captured, slot index restarts at zero.
//   scan    - slot i read, compared the cycle after; first matching key and
//             lowest free slot recorded; ends on a match or after the last
//             slot.
//   finish  - write-back (insert/replace, free on remove, change) and result
//             loaded into the output register once that register is free.
// A result waiting on out_ready does not block the next accept; only the
// commit of the following item waits for it.

module keyed_value_table #(
    parameter int ENTRIES    = 64,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            action,
    input  wire logic [KEY_BITS-1:0]   key,
    input  wire logic [VALUE_BITS-1:0] value_in,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0]                 status,
    output logic [VALUE_BITS-1:0]      value_out
);

    kvt_pkg::cmd_t  cmd;
    kvt_pkg::stat_t stat;

    kvt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd_o     (cmd),
        .stat_i    (stat)
    );

    kvt_datapath #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_i     (cmd),
        .stat_o    (stat),
        .action    (action),
        .key       (key),
        .value_in  (value_in),
        .status    (status),
        .value_out (value_out)
    );

endmodule

`default_nettype wire

// ===== tb/keyed_value_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_value_table_tb: self-checking bench for the keyed value table
// Runs a short table of directed requests, a fill-to-full and drain burst,
// then random insert/remove/find/change traffic over a small key pool. A
// shadow copy of the slot array predicts untyped results. Both handshakes
// idle at random, and the result side sometimes holds off for a long time.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_value_table_tb;

    localparam int N_SLOTS     = 64;
    localparam int KEY_W       = 16;
    localparam int VAL_W       = 32;
    localparam int POOL_SIZE   = 80;      // more keys than slots, so the table can fill
    localparam int PHASE_ITEMS = 400;
    localparam int HOLD_CYCLES = 300;     // long result-side hold-off
    localparam int SETTLE      = N_SLOTS + 8;
    localparam int CYCLE_LIMIT = 1_000_000;

    // one result item as the bench sees it
    typedef struct packed {
        kvt_pkg::result_t  st;
        logic [VAL_W-1:0]  val;
    } kv_result_t;

    // directed row: request plus an optional hand-written result
    typedef struct packed {
        kvt_pkg::action_t  act;
        logic [KEY_W-1:0]  k;
        logic [VAL_W-1:0]  v;
        logic              typed;
        kvt_pkg::result_t  st;
        logic [VAL_W-1:0]  val;
    } directed_row_t;

    localparam int N_DIRECTED = 23;

    // Rows with typed = 1 carry results obvious from the request history;
    // the rest go through the shadow table.
    localparam directed_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
        // empty table: every lookup misses
        '{kvt_pkg::ACT_FIND, 16'h0000, 32'h0000_0000, 1'b1, kvt_pkg::RES_NOT_FOUND, 32'h0},
        '{kvt_pkg::ACT_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, kvt_pkg::RES_NOT_FOUND, 32'h0},
        '{kvt_pkg::ACT_CHANGE, 16'h1234, 32'hDEAD_BEEF, 1'b1, kvt_pkg::RES_NOT_FOUND, 32'h0},
        // extreme keys and values
        '{kvt_pkg::ACT_INSERT, 16'h0000, 32'h0000_0000, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'hFFFF, 32'h0000_0000, 1'b1, kvt_pkg::RES_OK, 32'hFFFF_FFFF},
        '{kvt_pkg::ACT_FIND, 16'h0000, 32'hFFFF_FFFF, 1'b1, kvt_pkg::RES_OK, 32'h0},
        // insert of an existing key replaces, returns zero
        '{kvt_pkg::ACT_INSERT, 16'hFFFF, 32'h5A5A_5A5A, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'hFFFF, 32'h0000_0000, 1'b1, kvt_pkg::RES_OK, 32'h5A5A_5A5A},
        // change keeps the slot valid
        '{kvt_pkg::ACT_CHANGE, 16'h0000, 32'hA5A5_A5A5, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'h0000, 32'h0000_0000, 1'b1, kvt_pkg::RES_OK, 32'hA5A5_A5A5},
        // remove hands back the value and frees the slot
        '{kvt_pkg::ACT_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, kvt_pkg::RES_OK, 32'hA5A5_A5A5},
        '{kvt_pkg::ACT_FIND, 16'h0000, 32'h0000_0000, 1'b1, kvt_pkg::RES_NOT_FOUND, 32'h0},
        '{kvt_pkg::ACT_CHANGE, 16'h0000, 32'h0000_0001, 1'b1, kvt_pkg::RES_NOT_FOUND, 32'h0},
        // freed slot 0 is reused first
        '{kvt_pkg::ACT_INSERT, 16'h8000, 32'h8000_0000, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_INSERT, 16'h0001, 32'h0000_0001, 1'b1, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'h8000, 32'h0000_0000, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_REMOVE, 16'hFFFF, 32'h0000_0000, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_REMOVE, 16'h8000, 32'h0000_0000, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_INSERT, 16'hFFFF, 32'h1234_5678, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'h0001, 32'h0000_0000, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_CHANGE, 16'hFFFF, 32'h0000_0000, 1'b0, kvt_pkg::RES_OK, 32'h0},
        '{kvt_pkg::ACT_FIND, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, kvt_pkg::RES_OK, 32'h0}
    };

    // ---------------------------------------------------------------- DUT I/O
    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        action;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value_in;
    logic              out_valid;
    logic              out_ready;
    logic [1:0]        status;
    logic [VAL_W-1:0]  value_out;

    keyed_value_table #(
        .ENTRIES    (N_SLOTS),
        .KEY_BITS   (KEY_W),
        .VALUE_BITS (VAL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key       (key),
        .value_in  (value_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .value_out (value_out)
    );

    // ------------------------------------------------------- shadow table
    logic [KEY_W-1:0]  slot_key   [N_SLOTS];
    logic [VAL_W-1:0]  slot_value [N_SLOTS];
    bit                slot_used  [N_SLOTS];

    kv_result_t        pending_results [$];    // oldest at the front
    kv_result_t        oldest;
    int unsigned       mismatches;
    int unsigned       cycle_count;

    // random idling, in percent per cycle
    int unsigned       idle_in_pct;
    int unsigned       idle_out_pct;

    // long hold-off requests from the stimulus side; the receiver serves them
    int unsigned       hold_requests;
    int unsigned       holds_done;

    logic [KEY_W-1:0]  key_pool [POOL_SIZE];

    // Apply one request to the shadow table and return its result.
    // Hit = the valid slot holding the key; new keys go to the lowest free slot.
    function automatic void apply_request(input kvt_pkg::action_t act,
                                          input logic [KEY_W-1:0] k,
                                          input logic [VAL_W-1:0] v,
                                          output kv_result_t res);
        int hit_idx;
        int free_idx;
        hit_idx  = -1;
        free_idx = -1;
        for (int i = 0; i < N_SLOTS; i++)
        begin
            if (slot_used[i] && slot_key[i] == k && hit_idx < 0)
                hit_idx = i;
            if (!slot_used[i] && free_idx < 0)
                free_idx = i;
        end
        res.st  = kvt_pkg::RES_OK;
        res.val = '0;
        unique case (act)
            kvt_pkg::ACT_INSERT:
                if (hit_idx >= 0)
                    slot_value[hit_idx] = v;
                else if (free_idx >= 0)
                begin
                    slot_key[free_idx]   = k;
                    slot_value[free_idx] = v;
                    slot_used[free_idx]  = 1'b1;
                end
                else
                    res.st = kvt_pkg::RES_FULL;
            kvt_pkg::ACT_REMOVE:
                if (hit_idx >= 0)
                begin
                    res.val            = slot_value[hit_idx];
                    slot_used[hit_idx] = 1'b0;
                end
                else
                    res.st = kvt_pkg::RES_NOT_FOUND;
            kvt_pkg::ACT_FIND:
                if (hit_idx >= 0)
                    res.val = slot_value[hit_idx];
                else
                    res.st = kvt_pkg::RES_NOT_FOUND;
            kvt_pkg::ACT_CHANGE:
                if (hit_idx >= 0)
                    slot_value[hit_idx] = v;
                else
                    res.st = kvt_pkg::RES_NOT_FOUND;
        endcase
    endfunction

    // Keys mostly come from the pool so hits, replaces and a full table all
    // happen; the rest are fully random and nearly always miss.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(99) < 85)
            return key_pool[$urandom_range(POOL_SIZE-1)];
        return KEY_W'($urandom);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return VAL_W'($urandom);
    endfunction

    // Filling segments lean on insert, draining segments on remove.
    function automatic kvt_pkg::action_t pick_action(input bit filling);
        int unsigned r;
        r = $urandom_range(99);
        if (filling)
        begin
            if (r < 55) return kvt_pkg::ACT_INSERT;
            if (r < 65) return kvt_pkg::ACT_REMOVE;
            if (r < 85) return kvt_pkg::ACT_FIND;
            return kvt_pkg::ACT_CHANGE;
        end
        if (r < 15) return kvt_pkg::ACT_INSERT;
        if (r < 65) return kvt_pkg::ACT_REMOVE;
        if (r < 85) return kvt_pkg::ACT_FIND;
        return kvt_pkg::ACT_CHANGE;
    endfunction

    // ---------------------------------------------------------------- clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit; a stuck handshake ends up here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $time, cycle_count, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer one request and wait for the handshake. The result is predicted
    // at the accepting edge; a directed row may supply its own result.
    task automatic send_request(input kvt_pkg::action_t act,
                                input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v,
                                input bit typed,
                                input kv_result_t typed_res);
        kv_result_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        key      <= k;
        value_in <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        apply_request(act, k, v, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Drop valid and hold off until every outstanding result is back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------- result side
    // Random stalls, plus a long hold-off whenever the stimulus asks for one.
    // During the hold the block parks one result and one request, then stalls
    // its input.
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_requests != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_done = holds_done + 1;
            end
            else
                out_ready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    // Check every accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing outstanding: status %0d value %h",
                         $time, status, value_out);
                mismatches++;
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (status !== oldest.st)
                begin
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, oldest.st, status);
                    mismatches++;
                end
                if (value_out !== oldest.val)
                begin
                    $display("%0t: value_out mismatch: expected %h, got %h",
                             $time, oldest.val, value_out);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------- stimulus
    initial
    begin : stimulus
        bit                filling;
        int unsigned       seg_left;
        int                idx;
        bit                dup;
        logic [KEY_W-1:0]  cand;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = kvt_pkg::ACT_INSERT;
        key           = '0;
        value_in      = '0;
        mismatches    = 0;
        cycle_count   = 0;
        hold_requests = 0;
        holds_done    = 0;
        idle_in_pct   = 8;
        idle_out_pct  = 65;

        // distinct pool keys, both extremes included
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
        begin
            do
            begin
                cand = KEY_W'($urandom);
                dup  = 1'b0;
                for (int j = 0; j < i; j++)
                    if (key_pool[j] == cand)
                        dup = 1'b1;
            end
            while (dup);
            key_pool[i] = cand;
        end

        // Asynchronous reset, released at a falling edge. The block runs a
        // clearing pass afterwards; in_ready stays low until it is done.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // -- directed table
        for (int r = 0; r < N_DIRECTED; r++)
            send_request(DIRECTED_ROWS[r].act, DIRECTED_ROWS[r].k, DIRECTED_ROWS[r].v,
                         DIRECTED_ROWS[r].typed,
                         '{DIRECTED_ROWS[r].st, DIRECTED_ROWS[r].val});
        wait_drained();

        // -- fill to full: distinct keys until inserts report full, replace
        //    while full, free one slot and refill it, then drain everything
        for (int i = 0; i < N_SLOTS + 4; i++)
            send_request(kvt_pkg::ACT_INSERT, key_pool[i], pick_value(), 1'b0, '0);
        send_request(kvt_pkg::ACT_INSERT, key_pool[5], pick_value(), 1'b0, '0);
        send_request(kvt_pkg::ACT_REMOVE, key_pool[10], '0, 1'b0, '0);
        send_request(kvt_pkg::ACT_INSERT, key_pool[70], pick_value(), 1'b0, '0);
        send_request(kvt_pkg::ACT_FIND, key_pool[70], '0, 1'b0, '0);
        send_request(kvt_pkg::ACT_INSERT, key_pool[71], pick_value(), 1'b0, '0);
        send_request(kvt_pkg::ACT_CHANGE, key_pool[3], pick_value(), 1'b0, '0);
        for (int i = 0; i < POOL_SIZE; i++)
            send_request(kvt_pkg::ACT_REMOVE, key_pool[i], pick_value(), 1'b0, '0);
        wait_drained();

        // -- random traffic in three idling regimes, fill and drain segments
        for (int phase = 0; phase < 3; phase++)
        begin
            unique case (phase)
                0:
                begin
                    idle_in_pct  = 8;
                    idle_out_pct = 65;
                end
                1:
                begin
                    idle_in_pct  = 65;
                    idle_out_pct = 8;
                end
                default:
                begin
                    idle_in_pct  = 0;
                    idle_out_pct = 0;
                end
            endcase
            filling  = 1'b1;
            seg_left = $urandom_range(120, 40);
            for (idx = 0; idx < PHASE_ITEMS; idx++)
            begin
                // long hold-off while requests keep coming
                if (idx == 100 && phase != 1)
                    hold_requests = hold_requests + 1;
                if (seg_left == 0)
                begin
                    filling  = !filling;
                    seg_left = $urandom_range(120, 40);
                end
                seg_left--;
                send_request(pick_action(filling), pick_key(), pick_value(), 1'b0, '0);
            end
            wait_drained();
        end

        // nothing outstanding; give a stray result time to show up
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
